### hw/rtl/rm2q_pkg.sv
package rm2q_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    // Magnitude of any vector component (radicand or off-diagonal pair).
    localparam int MAG_W      = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
    localparam int SV_W       = MAG_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int N_W        = 2 * MAG_W + 2;
    localparam int SQRT_STEPS = N_W / 2;
    localparam int R_W        = MAG_W + 1;
    localparam int QT_W       = FRAC_BITS + 1;
    localparam int DEN_W      = R_W + 1;
    localparam int REM_W      = MAG_W + FRAC_BITS + 3;
    localparam int QS_W       = ((QT_W + 1) > OUT_W) ? (QT_W + 1) : OUT_W;

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // Data that rides along the root and divider stages.
    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
        t_branch               br;
        logic                  degen;
    } t_side;

endpackage

### hw/rtl/rm2q_mat_if.sv
interface rm2q_mat_if;
    logic                            valid;
    logic                            ready;
    logic signed [rm2q_pkg::IN_W-1:0] col0_row0;
    logic signed [rm2q_pkg::IN_W-1:0] col0_row1;
    logic signed [rm2q_pkg::IN_W-1:0] col0_row2;
    logic signed [rm2q_pkg::IN_W-1:0] col1_row0;
    logic signed [rm2q_pkg::IN_W-1:0] col1_row1;
    logic signed [rm2q_pkg::IN_W-1:0] col1_row2;
    logic signed [rm2q_pkg::IN_W-1:0] col2_row0;
    logic signed [rm2q_pkg::IN_W-1:0] col2_row1;
    logic signed [rm2q_pkg::IN_W-1:0] col2_row2;

    modport source (
        output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
               col1_row2, col2_row0, col2_row1, col2_row2,
        input  ready
    );
    modport sink (
        input  valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
               col1_row2, col2_row0, col2_row1, col2_row2,
        output ready
    );
endinterface

### hw/rtl/rm2q_quat_if.sv
interface rm2q_quat_if;
    logic                              valid;
    logic                              ready;
    logic signed [rm2q_pkg::OUT_W-1:0] quat_x;
    logic signed [rm2q_pkg::OUT_W-1:0] quat_y;
    logic signed [rm2q_pkg::OUT_W-1:0] quat_z;
    logic signed [rm2q_pkg::OUT_W-1:0] quat_w;
    logic [1:0]                        branch_taken;
    logic                              degenerate;

    modport source (
        output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
        input  ready
    );
    modport sink (
        input  valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
        output ready
    );
endinterface

### hw/rtl/rotation_matrix_to_quaternion.sv
// Channel  | Dir | Beat
// i_mat    | in  | nine rotation entries, signed, FRAC_BITS fraction bits
// o_quat   | out | unit quaternion x/y/z/w, branch taken, degenerate flag
//
// One matrix enters per cycle while the output register is empty or taken.
// The square root and the dividers each resolve one bit per stage.
// Reset clears only the valid bits of the stages.
// All stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipeline and no beat is dropped or repeated.
module rotation_matrix_to_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rm2q_mat_if.sink    i_mat,
    rm2q_quat_if.source o_quat
);

    localparam int SV_W  = rm2q_pkg::SV_W;
    localparam int MAG_W = rm2q_pkg::MAG_W;
    localparam int SQ_W  = rm2q_pkg::SQ_W;
    localparam int N_W   = rm2q_pkg::N_W;
    localparam int SQS   = rm2q_pkg::SQRT_STEPS;
    localparam int R_W   = rm2q_pkg::R_W;
    localparam int QT_W  = rm2q_pkg::QT_W;
    localparam int DEN_W = rm2q_pkg::DEN_W;
    localparam int REM_W = rm2q_pkg::REM_W;
    localparam int QS_W  = rm2q_pkg::QS_W;
    localparam int OUT_W = rm2q_pkg::OUT_W;
    localparam int FB    = rm2q_pkg::FRAC_BITS;

    localparam logic signed [SV_W-1:0] ONE_S = SV_W'(1) << FB;
    localparam logic [QT_W-1:0]        ONE_Q = QT_W'(1) << FB;
    localparam logic signed [QS_W-1:0] ONE_O = QS_W'(1) << FB;

    logic w_adv;
    logic r_out_vld;

    assign w_adv       = !r_out_vld || o_quat.ready;
    assign i_mat.ready = w_adv;

    // ---------------------------------------------------------------- stage 1
    logic signed [SV_W-1:0] w_m0, w_m1, w_m2, w_m4, w_m5, w_m6, w_m8, w_m9, w_m10;
    logic signed [SV_W-1:0] w_diag, w_rad;
    logic signed [SV_W-1:0] n_v [4];
    rm2q_pkg::t_branch      w_br;

    assign w_m0  = SV_W'(i_mat.col0_row0);
    assign w_m1  = SV_W'(i_mat.col0_row1);
    assign w_m2  = SV_W'(i_mat.col0_row2);
    assign w_m4  = SV_W'(i_mat.col1_row0);
    assign w_m5  = SV_W'(i_mat.col1_row1);
    assign w_m6  = SV_W'(i_mat.col1_row2);
    assign w_m8  = SV_W'(i_mat.col2_row0);
    assign w_m9  = SV_W'(i_mat.col2_row1);
    assign w_m10 = SV_W'(i_mat.col2_row2);
    assign w_diag = w_m0 + w_m5 + w_m10 + ONE_S;

    always_comb begin
        if (w_diag > 0) begin
            w_br   = rm2q_pkg::BR_TRACE;
            w_rad  = w_diag;
            n_v[0] = w_m6 - w_m9;
            n_v[1] = w_m8 - w_m2;
            n_v[2] = w_m1 - w_m4;
            n_v[3] = w_diag;
        end else if (w_m0 > w_m5 && w_m0 > w_m10) begin
            w_br   = rm2q_pkg::BR_X;
            w_rad  = ONE_S + w_m0 - w_m5 - w_m10;
            n_v[0] = w_rad;
            n_v[1] = w_m4 + w_m1;
            n_v[2] = w_m2 + w_m8;
            n_v[3] = w_m6 - w_m9;
        end else if (w_m5 > w_m10) begin
            w_br   = rm2q_pkg::BR_Y;
            w_rad  = ONE_S + w_m5 - w_m0 - w_m10;
            n_v[0] = w_m4 + w_m1;
            n_v[1] = w_rad;
            n_v[2] = w_m9 + w_m6;
            n_v[3] = w_m8 - w_m2;
        end else begin
            w_br   = rm2q_pkg::BR_Z;
            w_rad  = ONE_S + w_m10 - w_m0 - w_m5;
            n_v[0] = w_m8 + w_m2;
            n_v[1] = w_m9 + w_m6;
            n_v[2] = w_rad;
            n_v[3] = w_m1 - w_m4;
        end
    end

    logic signed [SV_W-1:0] r1_v [4];
    rm2q_pkg::t_branch      r1_br;
    logic                   r1_dg;
    logic                   r1_vld;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v  <= n_v;
            r1_br <= w_br;
            r1_dg <= (w_rad <= 0);
        end
    end

    // ------------------------------------------------------ stage 2: magnitudes
    rm2q_pkg::t_side n2_sd, r2_sd;
    logic            r2_vld;

    always_comb begin
        n2_sd.br    = r1_br;
        n2_sd.degen = r1_dg;
        for (int i = 0; i < 4; i++) begin
            logic signed [SV_W-1:0] t_abs;
            t_abs           = r1_v[i][SV_W-1] ? -r1_v[i] : r1_v[i];
            n2_sd.neg[i]    = r1_v[i][SV_W-1];
            n2_sd.mag[i]    = t_abs[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sd <= n2_sd;
        end
    end

    // --------------------------------------------------------- stage 3: squares
    logic [SQ_W-1:0] r3_sq [4];
    rm2q_pkg::t_side r3_sd;
    logic            r3_vld;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r3_sq[i] <= SQ_W'(r2_sd.mag[i]) * SQ_W'(r2_sd.mag[i]);
            end
            r3_sd <= r2_sd;
        end
    end

    // ----------------------------------- stage 4 and root stages, one bit each
    logic [N_W-1:0]  r_rt_n   [SQS+1];
    logic [N_W-1:0]  r_rt_res [SQS+1];
    rm2q_pkg::t_side r_rt_sd  [SQS+1];
    logic            r_rt_vld [SQS+1];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rt_n[0]   <= N_W'(r3_sq[0]) + N_W'(r3_sq[1]) + N_W'(r3_sq[2])
                         + N_W'(r3_sq[3]);
            r_rt_res[0] <= '0;
            r_rt_sd[0]  <= r3_sd;
        end
    end

    for (genvar k = 1; k <= SQS; k++) begin : g_root
        localparam logic [N_W-1:0] BIT = N_W'(1) << (2 * (SQS - k));
        logic [N_W-1:0] w_trial;

        assign w_trial = r_rt_res[k-1] + BIT;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rt_sd[k] <= r_rt_sd[k-1];
                if (r_rt_n[k-1] >= w_trial) begin
                    r_rt_n[k]   <= r_rt_n[k-1] - w_trial;
                    r_rt_res[k] <= (r_rt_res[k-1] >> 1) + BIT;
                end else begin
                    r_rt_n[k]   <= r_rt_n[k-1];
                    r_rt_res[k] <= r_rt_res[k-1] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_rt_vld[k] <= r_rt_vld[k-1];
            end
        end
    end

    // ------------------------------------- divider set-up and one-bit stages
    logic [3:0][REM_W-1:0] r_dv_rem [QT_W+1];
    logic [3:0][QT_W-1:0]  r_dv_q   [QT_W+1];
    logic [DEN_W-1:0]      r_dv_den [QT_W+1];
    rm2q_pkg::t_side       r_dv_sd  [QT_W+1];
    logic                  r_dv_vld [QT_W+1];
    logic [R_W-1:0]        w_root;

    // The root is never zero for a rotation; the guard keeps the divider sane.
    assign w_root = (r_rt_res[SQS][R_W-1:0] == '0) ? R_W'(1) : r_rt_res[SQS][R_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r_dv_rem[0][i] <= (REM_W'(r_rt_sd[SQS].mag[i]) << (FB + 1))
                                + REM_W'(w_root);
                r_dv_q[0][i]   <= '0;
            end
            r_dv_den[0] <= {w_root, 1'b0};
            r_dv_sd[0]  <= r_rt_sd[SQS];
        end
    end

    for (genvar j = 1; j <= QT_W; j++) begin : g_div
        logic [REM_W-1:0] w_sub;

        assign w_sub = REM_W'(r_dv_den[j-1]) << (QT_W - j);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int i = 0; i < 4; i++) begin
                    if (r_dv_rem[j-1][i] >= w_sub) begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i] - w_sub;
                        r_dv_q[j][i]   <= {r_dv_q[j-1][i][QT_W-2:0], 1'b1};
                    end else begin
                        r_dv_rem[j][i] <= r_dv_rem[j-1][i];
                        r_dv_q[j][i]   <= {r_dv_q[j-1][i][QT_W-2:0], 1'b0};
                    end
                end
                r_dv_den[j] <= r_dv_den[j-1];
                r_dv_sd[j]  <= r_dv_sd[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (w_adv) begin
                r_dv_vld[j] <= r_dv_vld[j-1];
            end
        end
    end

    // ------------------------------------------------------------ output stage
    logic signed [QS_W-1:0] n_q [4];
    logic [OUT_W-1:0]       r_q [4];
    rm2q_pkg::t_branch      r_br;
    logic                   r_dg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [QT_W-1:0] t_sat;
            t_sat  = (r_dv_q[QT_W][i] > ONE_Q) ? ONE_Q : r_dv_q[QT_W][i];
            n_q[i] = r_dv_sd[QT_W].neg[i] ? -QS_W'(t_sat) : QS_W'(t_sat);
            if (r_dv_sd[QT_W].degen) begin
                n_q[i] = (i == 3) ? ONE_O : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r_q[i] <= n_q[i][OUT_W-1:0];
            end
            r_br <= r_dv_sd[QT_W].br;
            r_dg <= r_dv_sd[QT_W].degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r_rt_vld[0] <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (w_adv) begin
            r1_vld      <= i_mat.valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r_rt_vld[0] <= r3_vld;
            r_dv_vld[0] <= r_rt_vld[SQS];
            r_out_vld   <= r_dv_vld[QT_W];
        end
    end

    assign o_quat.valid        = r_out_vld;
    assign o_quat.quat_x       = r_q[0];
    assign o_quat.quat_y       = r_q[1];
    assign o_quat.quat_z       = r_q[2];
    assign o_quat.quat_w       = r_q[3];
    assign o_quat.branch_taken = r_br;
    assign o_quat.degenerate   = r_dg;

    // ---------------------------------------------------------------- checks
    a_trace_never_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_br == rm2q_pkg::BR_TRACE |-> !r_dg)
        else $error("trace branch reported as degenerate");

    a_degenerate_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_dg |-> r_q[0] == '0 && r_q[1] == '0 && r_q[2] == '0
                              && r_q[3] == ONE_O[OUT_W-1:0])
        else $error("degenerate beat is not the identity quaternion");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mat.valid && i_mat.ready |=> r1_vld)
        else $error("accepted beat missing from first stage");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_quat.ready |=> r_out_vld && $stable(r_dv_vld[QT_W]))
        else $error("pipeline moved during a stall");

endmodule

### tb/sv/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;

    localparam longint ONE       = longint'(1) << rm2q_pkg::FRAC_BITS;
    localparam int     LATENCY   = 6 + rm2q_pkg::SQRT_STEPS + rm2q_pkg::QT_W;
    localparam int     IDLE_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] m[9];
    } t_matrix;

    typedef struct {
        logic [15:0]       qx, qy, qz, qw;
        rm2q_pkg::t_branch br;
        logic              degen;
    } t_quat;

    logic i_clk;
    logic i_rst_n;

    rm2q_mat_if  mat_ch ();
    rm2q_quat_if quat_ch ();

    rotation_matrix_to_quaternion u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_ch.sink),
        .o_quat  (quat_ch.source)
    );

    t_quat  expected_quats[$];
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles;
    int     errors;
    int     beats_in;
    int     beats_out;
    int     idle_cycles;
    int     degen_seen;
    int     branch_seen[4];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Integer square root, floor.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] scale_component(input longint v, input longint unsigned r);
        longint unsigned a;
        longint unsigned q;
        longint          s;
        a = (v < 0) ? longint'(-v) : longint'(v);
        q = (2 * a * longint'(ONE) + r) / (2 * r);
        if (q > longint'(ONE)) q = ONE;
        s = (v < 0) ? -longint'(q) : longint'(q);
        return s[15:0];
    endfunction

    function automatic t_quat matrix_to_quat(input t_matrix mx);
        longint m0, m1, m2, m4, m5, m6, m8, m9, m10;
        longint v[4];
        longint rad;
        longint unsigned n, r, a;
        t_quat  q;
        m0 = mx.m[0]; m1 = mx.m[1]; m2 = mx.m[2];
        m4 = mx.m[3]; m5 = mx.m[4]; m6 = mx.m[5];
        m8 = mx.m[6]; m9 = mx.m[7]; m10 = mx.m[8];
        rad = m0 + m5 + m10 + ONE;
        if (rad > 0) begin
            q.br = rm2q_pkg::BR_TRACE;
            v = '{m6 - m9, m8 - m2, m1 - m4, rad};
        end else if (m0 > m5 && m0 > m10) begin
            q.br = rm2q_pkg::BR_X;
            rad  = ONE + m0 - m5 - m10;
            v = '{rad, m4 + m1, m2 + m8, m6 - m9};
        end else if (m5 > m10) begin
            q.br = rm2q_pkg::BR_Y;
            rad  = ONE + m5 - m0 - m10;
            v = '{m4 + m1, rad, m9 + m6, m8 - m2};
        end else begin
            q.br = rm2q_pkg::BR_Z;
            rad  = ONE + m10 - m0 - m5;
            v = '{m8 + m2, m9 + m6, rad, m1 - m4};
        end
        q.degen = (rad <= 0);
        if (q.degen) begin
            q.qx = '0; q.qy = '0; q.qz = '0;
            q.qw = ONE[15:0];
        end else begin
            n = 0;
            for (int i = 0; i < 4; i++) begin
                a  = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
                n += a * a;
            end
            r = floor_sqrt(n);
            if (r == 0) r = 1;
            q.qx = scale_component(v[0], r);
            q.qy = scale_component(v[1], r);
            q.qz = scale_component(v[2], r);
            q.qw = scale_component(v[3], r);
        end
        return q;
    endfunction

    // Valid stays high from one beat to the next unless the sender idles.
    task automatic send_matrix(input t_matrix mx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        mat_ch.valid     <= 1'b1;
        mat_ch.col0_row0 <= mx.m[0];
        mat_ch.col0_row1 <= mx.m[1];
        mat_ch.col0_row2 <= mx.m[2];
        mat_ch.col1_row0 <= mx.m[3];
        mat_ch.col1_row1 <= mx.m[4];
        mat_ch.col1_row2 <= mx.m[5];
        mat_ch.col2_row0 <= mx.m[6];
        mat_ch.col2_row1 <= mx.m[7];
        mat_ch.col2_row2 <= mx.m[8];
        do @(posedge i_clk); while (!mat_ch.ready);
        expected_quats.push_back(matrix_to_quat(mx));
        beats_in++;
        @(negedge i_clk);
    endtask

    function automatic t_matrix make_matrix(input int d0, d1, d2, d3, d4, d5, d6, d7, d8);
        t_matrix mx;
        mx.m = '{d0[15:0], d1[15:0], d2[15:0], d3[15:0], d4[15:0],
                 d5[15:0], d6[15:0], d7[15:0], d8[15:0]};
        return mx;
    endfunction

    // Fully random entries, entries within +-ONE, or small off-diagonals with one diagonal
    // entry near +ONE and the rest near -ONE; this steers the diagonal so each branch is well exercised.
    function automatic t_matrix random_matrix(input int style);
        t_matrix mx;
        int      o;
        o = int'(ONE);
        for (int i = 0; i < 9; i++) mx.m[i] = 16'($urandom);
        case (style)
            0: ;
            1: begin
                for (int i = 0; i < 9; i++) mx.m[i] = 16'($urandom_range(2 * o) - o);
            end
            default: begin
                int k;
                k = $urandom_range(2);
                for (int i = 0; i < 9; i++) mx.m[i] = 16'($urandom_range(o / 2) - o / 4);
                mx.m[0] = 16'(-o + int'($urandom_range(o / 4)));
                mx.m[4] = 16'(-o + int'($urandom_range(o / 4)));
                mx.m[8] = 16'(-o + int'($urandom_range(o / 4)));
                mx.m[k * 4] = 16'(o - int'($urandom_range(o / 4)));
            end
        endcase
        return mx;
    endfunction

    task automatic drain();
        int guard;
        guard = 0;
        mat_ch.valid <= 1'b0;
        while (expected_quats.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    task automatic test_directed();
        int o;
        o = int'(ONE);
        send_matrix(make_matrix(o, 0, 0, 0, o, 0, 0, 0, o));
        send_matrix(make_matrix(o, 0, 0, 0, -o, 0, 0, 0, -o));
        send_matrix(make_matrix(-o, 0, 0, 0, o, 0, 0, 0, -o));
        send_matrix(make_matrix(-o, 0, 0, 0, -o, 0, 0, 0, o));
        send_matrix(make_matrix(-o, 0, 0, 0, -o, 0, 0, 0, -o));
        send_matrix(make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                                -32768, 32767, -32768));
        send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767));
        send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768));
        send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_matrix(make_matrix(-o, 5, 7, -3, -o, 9, 11, -13, -o));
        send_matrix(make_matrix(-o, 0, 0, 0, 0, 0, 0, 0, -32768));
        send_matrix(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        send_matrix(make_matrix(0, o, 0, -o, 0, 0, 0, 0, o));
        send_matrix(make_matrix(-o / 2, 32767, -32768, -32768, -o / 2, 32767,
                                32767, -32768, -o - 1));
        send_matrix(make_matrix(-o - 1, 0, 0, 0, -o - 1, 0, 0, 0, -o - 1));
        send_matrix(make_matrix(-o + 1, 1, -1, 1, -o, -1, 1, -1, -o));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_matrix(random_matrix($urandom_range(2)));
        end
    endtask

    // The receiver holds off for a long stretch so the pipeline fills and
    // back-pressures the sender.
    task automatic test_backpressure();
        hold_cycles = 3 * LATENCY;
        test_random(LATENCY + 40);
    endtask

    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            beats_out++;
            if (expected_quats.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_q = expected_quats.pop_front();
                if (quat_ch.degenerate) degen_seen++;
                branch_seen[quat_ch.branch_taken]++;
                if (quat_ch.quat_x !== exp_q.qx) begin
                    $error("quat_x expected %0d actual %0d",
                           $signed(exp_q.qx), quat_ch.quat_x);
                    errors++;
                end
                if (quat_ch.quat_y !== exp_q.qy) begin
                    $error("quat_y expected %0d actual %0d",
                           $signed(exp_q.qy), quat_ch.quat_y);
                    errors++;
                end
                if (quat_ch.quat_z !== exp_q.qz) begin
                    $error("quat_z expected %0d actual %0d",
                           $signed(exp_q.qz), quat_ch.quat_z);
                    errors++;
                end
                if (quat_ch.quat_w !== exp_q.qw) begin
                    $error("quat_w expected %0d actual %0d",
                           $signed(exp_q.qw), quat_ch.quat_w);
                    errors++;
                end
                if (quat_ch.branch_taken !== exp_q.br) begin
                    $error("branch_taken expected %0d actual %0d",
                           exp_q.br, quat_ch.branch_taken);
                    errors++;
                end
                if (quat_ch.degenerate !== exp_q.degen) begin
                    $error("degenerate expected %0d actual %0d",
                           exp_q.degen, quat_ch.degenerate);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            quat_ch.ready <= 1'b0;
        end else begin
            quat_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((mat_ch.valid && mat_ch.ready) || (quat_ch.valid && quat_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("rotation_matrix_to_quaternion_test NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors        = 0;
        beats_in      = 0;
        beats_out     = 0;
        idle_cycles   = 0;
        degen_seen    = 0;
        hold_cycles   = 0;
        branch_seen   = '{0, 0, 0, 0};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        mat_ch.valid  = 1'b0;
        mat_ch.col0_row0 = '0; mat_ch.col0_row1 = '0; mat_ch.col0_row2 = '0;
        mat_ch.col1_row0 = '0; mat_ch.col1_row1 = '0; mat_ch.col1_row2 = '0;
        mat_ch.col2_row0 = '0; mat_ch.col2_row1 = '0; mat_ch.col2_row2 = '0;
        quat_ch.ready = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 26;
        recv_idle_pct = 63;
        test_directed();
        test_random(600);
        test_backpressure();

        send_idle_pct = 63;
        recv_idle_pct = 26;
        test_random(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550);
        test_backpressure();

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Sent %0d matrices, checked %0d quaternions (%0d degenerate).",
                 beats_in, beats_out, degen_seen);
        $display("Branches seen: trace %0d, x %0d, y %0d, z %0d.",
                 branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
        if (errors == 0 && expected_quats.size() == 0) begin
            $display("rotation_matrix_to_quaternion_test OK");
        end else begin
            if (expected_quats.size() != 0) begin
                $error("%0d expected results never arrived", expected_quats.size());
            end
            $display("rotation_matrix_to_quaternion_test NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/rm2q_pkg.sv
hw/rtl/rm2q_mat_if.sv
hw/rtl/rm2q_quat_if.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_test.sv
